[rtl/mwo_pkg.sv]
package mwo_pkg;

  localparam int unsigned EntryDigits    = 4;
  localparam int unsigned EntryIdxW      = 2;
  localparam int unsigned EntryPosW      = 3;
  localparam int unsigned DigitW         = 4;
  localparam int unsigned SecondsW       = 13;
  localparam int unsigned TickW          = 16;
  localparam int unsigned MinutesW       = 7;
  localparam int unsigned SecPartW       = 6;

  localparam logic [SecondsW-1:0] MaxSeconds   = 13'd8191;
  localparam logic [SecondsW-1:0] ClampSeconds = 13'd5999;

  // floor(x / 60) == (x * 8739) >> 19 for every x up to 5999
  localparam logic [13:0] RecipSixty = 14'd8739;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipProdW = 27;

  localparam logic [3:0] KeyLastDigit = 4'd9;
  localparam logic [3:0] KeyStart     = 4'd10;
  localparam logic [3:0] KeyClear     = 4'd11;
  localparam logic [3:0] KeyAdd       = 4'd12;
  localparam logic [3:0] KeyDoor      = 4'd13;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam int unsigned ModNumW        = 16;
  localparam int unsigned ModDenW        = 8;
  localparam int unsigned ModBitsPerStep = 4;
  localparam int unsigned ModSteps       = ModNumW / ModBitsPerStep;
  localparam int unsigned ModCntW        = 2;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_TICKS_PER_SEC = 2'd0,
    CFG_BLINK_TICKS   = 2'd1,
    CFG_DONE_HOLD     = 2'd2,
    CFG_ADD_STEP      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_COOK  = 4'b0010,
    MODE_PAUSE = 4'b0100,
    MODE_DONE  = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    CODE_IDLE  = 2'd0,
    CODE_COOK  = 2'd1,
    CODE_PAUSE = 2'd2,
    CODE_DONE  = 2'd3
  } mode_code_e;

  typedef struct packed {
    logic              dig;
    logic              start;
    logic              clear;
    logic              add;
    logic              door;
    logic [DigitW-1:0] digit;
  } key_cmd_t;

  typedef struct packed {
    logic [1:0]        mode_code;
    logic              door_open;
    logic              magnetron;
    logic              green;
    logic              violet;
    logic              blank;
    logic [DigitW-1:0] min_tens;
    logic [DigitW-1:0] min_ones;
    logic [DigitW-1:0] sec_tens;
    logic [DigitW-1:0] sec_ones;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [ModNumW-1:0] dividend;
    logic [ModDenW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

  function automatic logic [DigitW-1:0] tens_of(input logic [MinutesW-1:0] x);
    logic [DigitW-1:0] t;
    t = '0;
    for (int i = 1; i < 10; i++) begin
      if (x >= MinutesW'(i * 10)) t = DigitW'(i);
    end
    return t;
  endfunction

  function automatic logic [DigitW-1:0] ones_of(input logic [MinutesW-1:0] x);
    logic [MinutesW-1:0] r;
    r = x - MinutesW'(tens_of(x)) * MinutesW'(10);
    return r[DigitW-1:0];
  endfunction

  function automatic logic [1:0] mode_to_code(input mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:  c = CODE_IDLE;
      MODE_COOK:  c = CODE_COOK;
      MODE_PAUSE: c = CODE_PAUSE;
      default:    c = CODE_DONE;
    endcase
    return c;
  endfunction

endpackage

[rtl/mwo_front.sv]
module mwo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              key_valid_i,
  input  logic [3:0]        key_code_i,
  output logic              full_o,
  input  logic              cmd_pop_i,
  output logic              cmd_empty_o,
  output mwo_pkg::key_cmd_t cmd_o
);
  import mwo_pkg::*;

  key_cmd_t              mem_q [QueueDepth];
  key_cmd_t              dec;
  logic [QueuePtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  wr_en, rd_en;

  // key classification
  always_comb begin
    dec.dig   = key_valid_i && (key_code_i <= KeyLastDigit);
    dec.start = key_valid_i && (key_code_i == KeyStart);
    dec.clear = key_valid_i && (key_code_i == KeyClear);
    dec.add   = key_valid_i && (key_code_i == KeyAdd);
    dec.door  = key_valid_i && (key_code_i == KeyDoor);
    dec.digit = key_code_i;
  end

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign cmd_empty_o = (cnt_q == '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && !cmd_empty_o;
  assign cmd_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) wptr_d = wptr_q + 1'b1;
    if (rd_en) rptr_d = rptr_q + 1'b1;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= dec;
  end

endmodule

[rtl/mwo_mod_unit.sv]
module mwo_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mwo_pkg::mod_req_t req_i,
  output mwo_pkg::mod_rsp_t rsp_o
);
  import mwo_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ModCntW-1:0] cnt_q, cnt_d;
  logic [ModNumW-1:0] num_q, num_d;
  logic [ModDenW-1:0] den_q, den_d;
  logic [ModDenW-1:0] rem_q, rem_d;

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    logic [ModDenW-1:0] r;
    logic [ModDenW:0]   t;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    r      = rem_q;
    t      = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int i = 0; i < ModBitsPerStep; i++) begin
        t = {r, num_q[ModNumW-1-i]};
        if (t >= {1'b0, den_q}) t = t - {1'b0, den_q};
        r = t[ModDenW-1:0];
      end
      rem_d = r;
      num_d = num_q << ModBitsPerStep;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ModCntW'(ModSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

[rtl/mwo_back.sv]
module mwo_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwo_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [mwo_pkg::CfgDataW-1:0]        cfg_data_i,
  input  mwo_pkg::key_cmd_t                   cmd_i,
  input  logic                                cmd_empty_i,
  output logic                                cmd_pop_o,
  output mwo_pkg::mod_req_t                   mod_req_o,
  input  mwo_pkg::mod_rsp_t                   mod_rsp_i,
  input  logic                                res_room_i,
  output logic                                res_push_o,
  output mwo_pkg::result_t                    res_o
);
  import mwo_pkg::*;

  typedef enum logic [5:0] {
    ST_WAIT = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_SPL1 = 6'b000100,
    ST_SPL2 = 6'b001000,
    ST_SPL3 = 6'b010000,
    ST_EMIT = 6'b100000
  } seq_e;

  seq_e                  state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [TickW-1:0]      tick_q, tick_d, tick_inc;
  logic [SecondsW-1:0]   rem_q, rem_d;
  logic [EntryPosW-1:0]  pos_q, pos_d;
  logic                  door_q, door_d;
  logic                  blink_q, blink_d;
  logic                  mag_q, mag_d, green_q, green_d, violet_q, violet_d;
  logic [DigitW-1:0]     entry_q [EntryDigits];
  logic [DigitW-1:0]     entry_d [EntryDigits];
  logic [DigitW-1:0]     shown_q [EntryDigits];
  logic [DigitW-1:0]     shown_d [EntryDigits];
  logic                  split_entry_q, split_entry_d;
  logic [SecondsW-1:0]   secs_q, secs_d;
  logic [MinutesW-1:0]   m_q, m_d;
  logic [SecPartW-1:0]   s_q, s_d;

  logic [7:0]            tps_q, blink_per_q, add_step_q;
  logic [15:0]           hold_q;

  logic                  second_due;
  logic [SecondsW-1:0]   rem_dec, rem_base, rem_added, rem_entered, rem_clamp;
  logic [SecondsW:0]     add_sum;
  logic [MinutesW-1:0]   entry_mins;
  logic [RecipProdW-1:0] recip_prod;
  logic [SecondsW-1:0]   sec_diff;
  logic [SecondsW-1:0]   mins_secs;

  assign tick_inc   = tick_q + 1'b1;
  assign second_due = (tick_inc >= {8'd0, tps_q});
  assign rem_dec    = (rem_q == '0) ? '0 : rem_q - 1'b1;
  assign rem_base   = (mode_q == MODE_COOK && second_due) ? rem_dec : rem_q;
  assign add_sum    = {1'b0, rem_base} + (SecondsW + 1)'(add_step_q);
  assign rem_added  = add_sum[SecondsW] ? MaxSeconds : add_sum[SecondsW-1:0];
  assign entry_mins = MinutesW'(entry_q[0]) * MinutesW'(10) + MinutesW'(entry_q[1]);
  assign rem_entered = SecondsW'(entry_mins) * SecondsW'(60)
                     + SecondsW'(entry_q[2]) * SecondsW'(10) + SecondsW'(entry_q[3]);
  assign rem_clamp  = (rem_q > ClampSeconds) ? ClampSeconds : rem_q;
  assign recip_prod = RecipProdW'(rem_clamp) * RecipProdW'(RecipSixty);
  assign mins_secs  = SecondsW'(m_q) * SecondsW'(60);
  assign sec_diff   = secs_q - mins_secs;

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    tick_d        = tick_q;
    rem_d         = rem_q;
    pos_d         = pos_q;
    door_d        = door_q;
    blink_d       = blink_q;
    mag_d         = mag_q;
    green_d       = green_q;
    violet_d      = violet_q;
    entry_d       = entry_q;
    shown_d       = shown_q;
    split_entry_d = split_entry_q;
    secs_d        = secs_q;
    m_d           = m_q;
    s_d           = s_q;
    cmd_pop_o     = 1'b0;
    res_push_o    = 1'b0;
    mod_req_o     = '0;

    unique case (state_q)
      ST_WAIT: begin
        if (!cmd_empty_i && res_room_i) begin
          cmd_pop_o     = 1'b1;
          tick_d        = tick_inc;
          door_d        = door_q ^ cmd_i.door;
          split_entry_d = 1'b0;
          state_d       = ST_EMIT;
          unique case (mode_q)
            MODE_IDLE: begin
              mag_d    = 1'b0;
              green_d  = 1'b0;
              violet_d = 1'b0;
              if (cmd_i.dig) begin
                if (pos_q < EntryPosW'(EntryDigits)) begin
                  entry_d[pos_q[EntryIdxW-1:0]] = cmd_i.digit;
                  shown_d = entry_d;
                  pos_d   = pos_q + 1'b1;
                end
              end else if (cmd_i.clear) begin
                rem_d = '0;
                pos_d = '0;
                for (int i = 0; i < EntryDigits; i++) begin
                  entry_d[i] = '0;
                  shown_d[i] = '0;
                end
              end else if (cmd_i.add) begin
                rem_d         = rem_added;
                split_entry_d = 1'b1;
                state_d       = ST_SPL1;
              end else if (cmd_i.start) begin
                rem_d = rem_entered;
                if (rem_entered != '0 && !door_d) begin
                  mode_d = MODE_COOK;
                  tick_d = '0;
                end
              end
            end
            MODE_COOK: begin
              mag_d    = 1'b1;
              green_d  = 1'b1;
              violet_d = 1'b0;
              if (door_d) begin
                mode_d = MODE_PAUSE;
              end else if (second_due && rem_dec == '0) begin
                tick_d  = '0;
                rem_d   = rem_dec;
                mode_d  = MODE_DONE;
                state_d = ST_SPL1;
              end else begin
                if (second_due) begin
                  tick_d  = '0;
                  rem_d   = rem_dec;
                  state_d = ST_SPL1;
                end
                if (cmd_i.clear) begin
                  mode_d = MODE_PAUSE;
                end else if (cmd_i.add) begin
                  rem_d         = rem_added;
                  split_entry_d = 1'b1;
                  state_d       = ST_SPL1;
                end
              end
            end
            MODE_PAUSE: begin
              mag_d   = 1'b0;
              green_d = 1'b1;
              if (cmd_i.clear) begin
                rem_d  = '0;
                pos_d  = '0;
                mode_d = MODE_IDLE;
                for (int i = 0; i < EntryDigits; i++) begin
                  entry_d[i] = '0;
                  shown_d[i] = '0;
                end
              end else if (cmd_i.start && !door_d) begin
                mode_d = MODE_COOK;
                tick_d = '0;
              end
            end
            default: begin
              mag_d   = 1'b0;
              green_d = 1'b0;
              if (tick_inc >= hold_q || cmd_i.clear || cmd_i.door) begin
                violet_d = 1'b0;
                blink_d  = 1'b0;
                rem_d    = '0;
                pos_d    = '0;
                mode_d   = MODE_IDLE;
                for (int i = 0; i < EntryDigits; i++) begin
                  entry_d[i] = '0;
                  shown_d[i] = '0;
                end
              end else begin
                mod_req_o.start    = 1'b1;
                mod_req_o.dividend = tick_inc;
                mod_req_o.divisor  = (blink_per_q == '0) ? 8'd1 : blink_per_q;
                state_d            = ST_MOD;
              end
            end
          endcase
        end
      end
      ST_MOD: begin
        if (mod_rsp_i.done) begin
          if (mod_rsp_i.rem_zero) begin
            blink_d  = ~blink_q;
            violet_d = ~violet_q;
          end
          state_d = ST_EMIT;
        end
      end
      ST_SPL1: begin
        secs_d  = rem_clamp;
        m_d     = recip_prod[RecipShift+MinutesW-1:RecipShift];
        state_d = ST_SPL2;
      end
      ST_SPL2: begin
        s_d     = sec_diff[SecPartW-1:0];
        state_d = ST_SPL3;
      end
      ST_SPL3: begin
        shown_d[0] = tens_of(m_q);
        shown_d[1] = ones_of(m_q);
        shown_d[2] = tens_of({1'b0, s_q});
        shown_d[3] = ones_of({1'b0, s_q});
        if (split_entry_q) entry_d = shown_d;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        res_push_o = 1'b1;
        state_d    = ST_WAIT;
      end
      default: state_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT;
      mode_q   <= MODE_IDLE;
      tick_q   <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      door_q   <= 1'b0;
      blink_q  <= 1'b0;
      mag_q    <= 1'b0;
      green_q  <= 1'b0;
      violet_q <= 1'b0;
      for (int i = 0; i < EntryDigits; i++) begin
        entry_q[i] <= '0;
        shown_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      tick_q   <= tick_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      door_q   <= door_d;
      blink_q  <= blink_d;
      mag_q    <= mag_d;
      green_q  <= green_d;
      violet_q <= violet_d;
      entry_q  <= entry_d;
      shown_q  <= shown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    split_entry_q <= split_entry_d;
    secs_q        <= secs_d;
    m_q           <= m_d;
    s_q           <= s_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= 8'd10;
      blink_per_q <= 8'd5;
      hold_q      <= 16'd50;
      add_step_q  <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TICKS_PER_SEC: tps_q       <= cfg_data_i[7:0];
        CFG_BLINK_TICKS:   blink_per_q <= cfg_data_i[7:0];
        CFG_DONE_HOLD:     hold_q      <= cfg_data_i;
        CFG_ADD_STEP:      add_step_q  <= cfg_data_i[7:0];
      endcase
    end
  end

  always_comb begin
    res_o.mode_code = mode_to_code(mode_q);
    res_o.door_open = door_q;
    res_o.magnetron = mag_q;
    res_o.green     = green_q;
    res_o.violet    = violet_q;
    res_o.blank     = blink_q;
    res_o.min_tens  = shown_q[0];
    res_o.min_ones  = shown_q[1];
    res_o.sec_tens  = shown_q[2];
    res_o.sec_ones  = shown_q[3];
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_room_i)
    else $error("result pushed without room");

  a_mod_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (mode_q == MODE_DONE))
    else $error("remainder wait outside done mode");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= EntryPosW'(EntryDigits))
    else $error("entry position out of range");

  a_pop_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != ST_WAIT))
    else $error("transaction taken without being carried out");

endmodule

[rtl/mwo_result_queue.sv]
module mwo_result_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mwo_pkg::result_t data_i,
  output logic             room_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mwo_pkg::result_t head_o
);
  import mwo_pkg::*;

  result_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  wr_en, rd_en;

  assign room_o  = (cnt_q != QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && room_o;
  assign rd_en   = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) wptr_d = wptr_q + 1'b1;
    if (rd_en) rptr_d = rptr_q + 1'b1;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= data_i;
  end

endmodule

[rtl/microwave_oven_controller.sv]
// microwave oven timer controller, one transaction per 100 ms tick
// input channel: drive key_valid_i/key_code_i with push; the tick is taken
//   on a clock edge with push high and full low. a two-entry queue holds
//   classified ticks, so push may continue while earlier ticks are at work
// result channel: while empty is low the ports show the oldest result
//   (mode, door, lamps, blank flag, MM:SS digits); pop takes it
// config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 ticks per second, 1 blink period, 2 done hold, 3 add step), no wait
// sequencing: a taken tick ends in the emit state, which pushes its result;
//   before it, the three-step divide by 60 and 10 runs when the display
//   digits are recomputed, and in done mode, unless the hold ends, the
//   remainder unit is waited on for the blink period
// the back end starts a tick only once the last one is pushed and the
//   two-entry result queue has room, so a stalled receiver fills the result
//   queue, then the input queue, and then raises full; nothing is dropped
// reset: idle mode, door closed, lamps off, time and digits zero, config
//   registers at 10, 5, 50 and 30; both queues empty
module microwave_oven_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          key_valid_i,
  input  logic [3:0]                    key_code_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    mode_code_o,
  output logic                          door_open_o,
  output logic                          magnetron_on_o,
  output logic                          green_on_o,
  output logic                          violet_on_o,
  output logic                          display_blank_o,
  output logic [3:0]                    show_min_tens_o,
  output logic [3:0]                    show_min_ones_o,
  output logic [3:0]                    show_sec_tens_o,
  output logic [3:0]                    show_sec_ones_o,
  input  logic                          cfg_we_i,
  input  logic [mwo_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [mwo_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mwo_pkg::*;

  key_cmd_t cmd;
  logic     cmd_empty, cmd_pop;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  result_t  res, head;
  logic     res_room, res_push;

  mwo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .key_valid_i (key_valid_i),
    .key_code_i  (key_code_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  mwo_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  mwo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .mod_req_o   (mod_req),
    .mod_rsp_i   (mod_rsp),
    .res_room_i  (res_room),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  mwo_result_queue u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .room_o  (res_room),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  assign mode_code_o     = head.mode_code;
  assign door_open_o     = head.door_open;
  assign magnetron_on_o  = head.magnetron;
  assign green_on_o      = head.green;
  assign violet_on_o     = head.violet;
  assign display_blank_o = head.blank;
  assign show_min_tens_o = head.min_tens;
  assign show_min_ones_o = head.min_ones;
  assign show_sec_tens_o = head.sec_tens;
  assign show_sec_ones_o = head.sec_ones;

endmodule
